FILE: hdl/u2g_pkg.sv
// Shared types and constants for the UTF-8 to GB2312 byte transcoder.
package u2g_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);

    localparam logic [10:0] CAP_RESET = 11'd512;
    localparam logic [7:0]  ASCII_MAX = 8'h7F;
    localparam logic [7:0]  LEAD3_LO  = 8'hE0;
    localparam logic [7:0]  LEAD3_HI  = 8'hEF;
    localparam logic [7:0]  LEAD2_LO  = 8'hC0;
    localparam logic [7:0]  LEAD2_HI  = 8'hDF;
    localparam logic [7:0]  QMARK     = 8'h3F;

    typedef struct packed {
        logic        valid;
        logic [23:0] utf8;
        logic [15:0] gb;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [TAB_AW-1:0] addr;
        entry_t            entry;
    } tab_wr_t;

    typedef struct packed {
        logic        clearing;
        logic        done;
        logic        hit;
        logic [15:0] gb;
    } tab_stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_SEARCH,
        ST_PUT,
        ST_FINISH
    } state_t;

endpackage

FILE: hdl/u2g_map_table.sv
// Mapping table memory with its clearing pass and a sequential first-match search.
module u2g_map_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  u2g_pkg::tab_wr_t    wr,
    input  logic                srch_start,
    input  logic [23:0]         srch_key,
    output u2g_pkg::tab_stat_t  stat
);

    localparam logic [u2g_pkg::TAB_AW-1:0] LAST_ADDR =
        u2g_pkg::TAB_AW'(u2g_pkg::TABLE_DEPTH - 1);

    u2g_pkg::entry_t mem [u2g_pkg::TABLE_DEPTH];
    u2g_pkg::entry_t rdata_reg;

    logic                      clearing_reg, clearing_next;
    logic [u2g_pkg::TAB_AW-1:0] clr_addr_reg, clr_addr_next;
    logic                      searching_reg, searching_next;
    logic                      issuing_reg, issuing_next;
    logic                      cmp_valid_reg, cmp_valid_next;
    logic                      cmp_last_reg, cmp_last_next;
    logic [u2g_pkg::TAB_AW-1:0] addr_reg, addr_next;
    logic [23:0]               key_reg, key_next;

    logic                      we;
    logic [u2g_pkg::TAB_AW-1:0] waddr;
    u2g_pkg::entry_t           wdata;
    logic                      hit;
    logic                      done;

    assign we    = clearing_reg | wr.en;
    assign waddr = clearing_reg ? clr_addr_reg : wr.addr;
    assign wdata = clearing_reg ? '0 : wr.entry;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[addr_reg];
    end

    // The entry read for the previous address is compared here, in the cycle after its address was issued.
    assign hit  = rdata_reg.valid && (rdata_reg.utf8 == key_reg);
    assign done = searching_reg && cmp_valid_reg && (hit || cmp_last_reg);

    always_comb begin
        clearing_next  = clearing_reg;
        clr_addr_next  = clr_addr_reg;
        searching_next = searching_reg;
        issuing_next   = issuing_reg;
        cmp_valid_next = 1'b0;
        cmp_last_next  = 1'b0;
        addr_next      = addr_reg;
        key_next       = key_reg;

        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR) begin
                clearing_next = 1'b0;
            end
        end

        if (srch_start) begin
            searching_next = 1'b1;
            issuing_next   = 1'b1;
            addr_next      = '0;
            key_next       = srch_key;
        end else if (done) begin
            searching_next = 1'b0;
            issuing_next   = 1'b0;
        end else if (searching_reg && issuing_reg) begin
            cmp_valid_next = 1'b1;
            cmp_last_next  = (addr_reg == LAST_ADDR);
            if (addr_reg == LAST_ADDR) begin
                issuing_next = 1'b0;
            end else begin
                addr_next = addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            searching_reg <= 1'b0;
            issuing_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
        end else begin
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            searching_reg <= searching_next;
            issuing_reg   <= issuing_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_last_reg  <= cmp_last_next;
        end
        addr_reg <= addr_next;
        key_reg  <= key_next;
    end

    assign stat.clearing = clearing_reg;
    assign stat.done     = done;
    assign stat.hit      = hit;
    assign stat.gb       = rdata_reg.gb;

endmodule

FILE: hdl/utf8_to_gb2312_byte_transcoder.sv
// Top level: byte sequencer that turns a UTF-8 stream into GB2312 bytes.
// Text bytes are taken one at a time: s_ready is high only in the idle state, so each byte is
// worked off before the next is taken, while a table write is taken every cycle.
// A three-byte lookup searches one table entry a cycle; output stalls hold the byte sequencer.
// After reset the table is cleared one entry a cycle, with s_ready low until it is done.
module utf8_to_gb2312_byte_transcoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_byte_in,
    input  logic        s_last_byte,
    input  logic [8:0]  s_entry_index,
    input  logic [23:0] s_entry_utf8,
    input  logic [15:0] s_entry_gb,
    input  logic        s_entry_valid,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_out_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    u2g_pkg::state_t state_reg, state_next;

    logic [2:0][7:0] buf_reg, buf_next;
    logic [1:0]      n_reg, n_next;
    logic            end_reg, end_next;
    logic [10:0]     emitted_reg, emitted_next;
    logic            discard_reg, discard_next;
    logic [10:0]     cap_reg;
    logic [7:0]      put_reg, put_next;
    logic [7:0]      lo_reg, lo_next;
    logic [1:0]      used_reg, used_next;
    logic            two_reg, two_next;
    logic            m_valid_reg, m_valid_next;
    logic [7:0]      m_byte_reg, m_byte_next;
    logic            m_last_reg, m_last_next;

    u2g_pkg::tab_wr_t   tab_wr;
    u2g_pkg::tab_stat_t tab_stat;
    logic               srch_start;

    logic [10:0] cap_eff;
    logic        full;
    logic        room2;
    logic [7:0]  head;
    logic [7:0]  miss_byte;
    logic [1:0]  miss_used;
    logic        out_free;
    logic        accept;
    logic [4:0]  shamt;

    u2g_map_table u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr         (tab_wr),
        .srch_start (srch_start),
        .srch_key   ({buf_reg[0], buf_reg[1], buf_reg[2]}),
        .stat       (tab_stat)
    );

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == u2g_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    assign tab_wr.en    = accept && s_mode &&
                          (32'(s_entry_index) < u2g_pkg::TABLE_DEPTH);
    assign tab_wr.addr  = u2g_pkg::TAB_AW'(s_entry_index);
    assign tab_wr.entry = '{valid: s_entry_valid, utf8: s_entry_utf8, gb: s_entry_gb};

    // A capacity of zero behaves as one, leaving room for the terminator only.
    assign cap_eff = (cap_reg == 11'd0) ? 11'd1 : cap_reg;
    assign full    = ({1'b0, emitted_reg} + 12'd1) >= {1'b0, cap_eff};
    assign room2   = ({1'b0, emitted_reg} + 12'd2) < {1'b0, cap_eff};
    assign head    = buf_reg[0];
    assign out_free = !m_valid_reg || m_ready;
    assign shamt   = {used_reg, 3'b000};

    always_comb begin
        if ((head inside {[u2g_pkg::LEAD3_LO:u2g_pkg::LEAD3_HI]}) && (n_reg == 2'd3)) begin
            miss_byte = u2g_pkg::QMARK;
            miss_used = 2'd3;
        end else if ((head inside {[u2g_pkg::LEAD2_LO:u2g_pkg::LEAD2_HI]}) &&
                     (n_reg >= 2'd2)) begin
            miss_byte = u2g_pkg::QMARK;
            miss_used = 2'd2;
        end else begin
            miss_byte = head;
            miss_used = 2'd1;
        end
    end

    always_comb begin
        state_next   = state_reg;
        buf_next     = buf_reg;
        n_next       = n_reg;
        end_next     = end_reg;
        emitted_next = emitted_reg;
        discard_next = discard_reg;
        put_next     = put_reg;
        lo_next      = lo_reg;
        used_next    = used_reg;
        two_next     = two_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        srch_start   = 1'b0;

        case (state_reg)
            u2g_pkg::ST_CLEAR: begin
                if (!tab_stat.clearing) begin
                    state_next = u2g_pkg::ST_IDLE;
                end
            end
            u2g_pkg::ST_IDLE: begin
                if (accept && !s_mode) begin
                    end_next = (s_byte_in == 8'd0) || s_last_byte;
                    if (discard_reg) begin
                        n_next = 2'd0;
                    end else if (s_byte_in != 8'd0 && n_reg != 2'd3) begin
                        buf_next[n_reg] = s_byte_in;
                        n_next          = n_reg + 2'd1;
                    end
                    state_next = u2g_pkg::ST_STEP;
                end
            end
            u2g_pkg::ST_STEP: begin
                if (n_reg == 2'd0) begin
                    state_next = u2g_pkg::ST_FINISH;
                end else if (full) begin
                    discard_next = 1'b1;
                    n_next       = 2'd0;
                    state_next   = u2g_pkg::ST_FINISH;
                end else if (head <= u2g_pkg::ASCII_MAX) begin
                    put_next   = head;
                    used_next  = 2'd1;
                    two_next   = 1'b0;
                    state_next = u2g_pkg::ST_PUT;
                end else if (n_reg != 2'd3 && !end_reg) begin
                    // Lead byte held until the rest of its sequence arrives.
                    state_next = u2g_pkg::ST_FINISH;
                end else if (n_reg == 2'd3 && room2) begin
                    srch_start = 1'b1;
                    state_next = u2g_pkg::ST_SEARCH;
                end else begin
                    put_next   = miss_byte;
                    used_next  = miss_used;
                    two_next   = 1'b0;
                    state_next = u2g_pkg::ST_PUT;
                end
            end
            u2g_pkg::ST_SEARCH: begin
                if (tab_stat.done) begin
                    if (tab_stat.hit) begin
                        put_next  = tab_stat.gb[15:8];
                        lo_next   = tab_stat.gb[7:0];
                        used_next = 2'd3;
                        two_next  = 1'b1;
                    end else begin
                        put_next  = miss_byte;
                        used_next = miss_used;
                        two_next  = 1'b0;
                    end
                    state_next = u2g_pkg::ST_PUT;
                end
            end
            u2g_pkg::ST_PUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = put_reg;
                    m_last_next  = 1'b0;
                    emitted_next = emitted_reg + 11'd1;
                    if (two_reg) begin
                        put_next = lo_reg;
                        two_next = 1'b0;
                    end else begin
                        buf_next   = buf_reg >> shamt;
                        n_next     = n_reg - used_reg;
                        state_next = u2g_pkg::ST_STEP;
                    end
                end
            end
            u2g_pkg::ST_FINISH: begin
                if (!end_reg) begin
                    state_next = u2g_pkg::ST_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = 8'd0;
                    m_last_next  = 1'b1;
                    n_next       = 2'd0;
                    buf_next     = '0;
                    emitted_next = 11'd0;
                    discard_next = 1'b0;
                    end_next     = 1'b0;
                    state_next   = u2g_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = u2g_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= u2g_pkg::ST_CLEAR;
            n_reg       <= 2'd0;
            end_reg     <= 1'b0;
            emitted_reg <= 11'd0;
            discard_reg <= 1'b0;
            cap_reg     <= u2g_pkg::CAP_RESET;
            two_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            buf_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            end_reg     <= end_next;
            emitted_reg <= emitted_next;
            discard_reg <= discard_next;
            two_reg     <= two_next;
            m_valid_reg <= m_valid_next;
            buf_reg     <= buf_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
        put_reg    <= put_next;
        lo_reg     <= lo_next;
        used_reg   <= used_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_last = m_last_reg;

endmodule

FILE: hdl/u2g_checker.sv
// Port-level checks for the transcoder, bound to the top level.
module u2g_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_mode,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_out_last
);

    // Reset starts the clearing pass, so nothing is taken or offered just after it.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("item taken or offered straight after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_out_last))
        else $error("stalled output item changed");

    a_text_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_mode |=> !s_ready)
        else $error("new item taken while a text byte is in work");

    a_table_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode && !m_valid |=> !m_valid)
        else $error("table write produced an output item");

endmodule

bind utf8_to_gb2312_byte_transcoder u2g_checker u_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_mode     (s_mode),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_out_last (m_out_last)
);

FILE: sim/tb.sv
// Self-checking testbench for the UTF-8 to GB2312 byte transcoder.
module tb;

    localparam int LAT_CYCLES  = u2g_pkg::TABLE_DEPTH + 64;
    localparam int CYCLE_LIMIT = 1000000;

    // One output byte as the block sends it.
    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } gb_byte_t;

    // One input item, optionally with its outputs written out by hand.
    typedef struct packed {
        logic        mode;
        logic [7:0]  b;
        logic        last;
        logic [8:0]  idx;
        logic [23:0] utf8;
        logic [15:0] gb;
        logic        ev;
        logic        typed;
        logic [2:0]  n_exp;
        logic [35:0] exp_bytes;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = 1'b0;
    logic [7:0]  s_byte_in = 8'h00;
    logic        s_last_byte = 1'b0;
    logic [8:0]  s_entry_index = 9'd0;
    logic [23:0] s_entry_utf8 = 24'd0;
    logic [15:0] s_entry_gb = 16'd0;
    logic        s_entry_valid = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_out_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data = 11'd0;

    utf8_to_gb2312_byte_transcoder u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_byte_in     (s_byte_in),
        .s_last_byte   (s_last_byte),
        .s_entry_index (s_entry_index),
        .s_entry_utf8  (s_entry_utf8),
        .s_entry_gb    (s_entry_gb),
        .s_entry_valid (s_entry_valid),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_out_last    (m_out_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predictor state.
    logic [10:0]     cap_reg = u2g_pkg::CAP_RESET;
    logic [7:0]      held [2];
    int              held_n = 0;
    int              sent_n = 0;
    bit              dropping = 1'b0;
    u2g_pkg::entry_t lut [u2g_pkg::TABLE_DEPTH];

    gb_byte_t    step_bytes [$];
    gb_byte_t    gb_expected [$];
    logic [23:0] known_keys [$];
    row_t        dir_rows [$];

    int  items_sent = 0;
    int  writes_sent = 0;
    int  strings_done = 0;
    int  results_seen = 0;
    int  fails = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    int  caps_used = 0;
    bit  steady = 1'b0;
    gb_byte_t want;

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    function automatic void put_gb(logic [7:0] v, logic fin);
        step_bytes.push_back(gb_byte_t'({v, fin}));
        if (!fin)
            sent_n++;
    endfunction

    function automatic int lut_find(logic [23:0] key);
        for (int i = 0; i < u2g_pkg::TABLE_DEPTH; i++)
            if (lut[i].valid && lut[i].utf8 == key)
                return i;
        return -1;
    endfunction

    // Works out the bytes one accepted item sends, into step_bytes.
    function automatic void predict_item(row_t r);
        logic [7:0] win [4];
        logic [7:0] h;
        int n, cap, used, hit;
        bit fin;
        if (r.mode) begin
            lut[r.idx] = '{valid: r.ev, utf8: r.utf8, gb: r.gb};
            return;
        end
        cap = (cap_reg == 11'd0) ? 1 : int'(cap_reg);
        fin = (r.b == 8'h00) || r.last;
        n = held_n;
        for (int i = 0; i < n; i++)
            win[i] = held[i];
        if (r.b != 8'h00) begin
            win[n] = r.b;
            n++;
        end
        if (dropping)
            n = 0;
        while (n > 0) begin
            h = win[0];
            if (sent_n + 1 >= cap) begin
                dropping = 1'b1;
                n = 0;
                break;
            end
            if (h <= u2g_pkg::ASCII_MAX) begin
                put_gb(h, 1'b0);
                used = 1;
            end else if (n < 3 && !fin) begin
                break;
            end else begin
                hit = -1;
                if (n >= 3 && sent_n + 2 < cap)
                    hit = lut_find({win[0], win[1], win[2]});
                if (hit >= 0) begin
                    put_gb(lut[hit].gb[15:8], 1'b0);
                    put_gb(lut[hit].gb[7:0], 1'b0);
                    used = 3;
                end else if (h >= u2g_pkg::LEAD3_LO && h <= u2g_pkg::LEAD3_HI && n >= 3) begin
                    put_gb(u2g_pkg::QMARK, 1'b0);
                    used = 3;
                end else if (h >= u2g_pkg::LEAD2_LO && h <= u2g_pkg::LEAD2_HI && n >= 2) begin
                    put_gb(u2g_pkg::QMARK, 1'b0);
                    used = 2;
                end else begin
                    put_gb(h, 1'b0);
                    used = 1;
                end
            end
            for (int i = used; i < n; i++)
                win[i - used] = win[i];
            n -= used;
        end
        if (fin) begin
            put_gb(8'h00, 1'b1);
            held_n = 0;
            sent_n = 0;
            dropping = 1'b0;
            return;
        end
        held_n = n;
        for (int i = 0; i < n; i++)
            held[i] = win[i];
    endfunction

    function automatic row_t mk_text(logic [7:0] b, logic fin, logic typed,
                                     logic [2:0] n, logic [35:0] e);
        row_t r;
        r.mode = 1'b0;
        r.b = b;
        r.last = fin;
        // Table fields are don't-care for text items, so they carry junk.
        r.idx = 9'($urandom);
        r.utf8 = 24'($urandom);
        r.gb = 16'($urandom);
        r.ev = 1'($urandom);
        r.typed = typed;
        r.n_exp = n;
        r.exp_bytes = e;
        return r;
    endfunction

    // A text byte that is neither last nor typed.
    function automatic row_t mk_byte(logic [7:0] b);
        return mk_text(b, 1'b0, 1'b0, 3'd0, 36'd0);
    endfunction

    function automatic row_t mk_write(logic [8:0] idx, logic [23:0] u, logic [15:0] g,
                                      logic ev);
        row_t r;
        r.mode = 1'b1;
        r.b = 8'($urandom);
        r.last = 1'($urandom);
        r.idx = idx;
        r.utf8 = u;
        r.gb = g;
        r.ev = ev;
        r.typed = 1'b1;
        r.n_exp = 3'd0;
        r.exp_bytes = '0;
        return r;
    endfunction

    task automatic send_item(input row_t r);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= r.mode;
        s_byte_in     <= r.b;
        s_last_byte   <= r.last;
        s_entry_index <= r.idx;
        s_entry_utf8  <= r.utf8;
        s_entry_gb    <= r.gb;
        s_entry_valid <= r.ev;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (r.mode)
            writes_sent++;
        else if (r.b == 8'h00 || r.last)
            strings_done++;
        step_bytes.delete();
        predict_item(r);
        if (r.typed) begin
            for (int i = 0; i < int'(r.n_exp); i++)
                gb_expected.push_back(gb_byte_t'(r.exp_bytes[35 - 9 * i -: 9]));
        end else begin
            for (int i = 0; i < step_bytes.size(); i++)
                gb_expected.push_back(step_bytes[i]);
        end
    endtask

    // Holds the sender back until every expected byte is out and the block is quiet.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (gb_expected.size() != 0)
            @(posedge aclk);
        repeat (LAT_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [10:0] v);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cap_reg = v;
        caps_used++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_string();
        row_t seq [$];
        row_t tail;
        logic [23:0] key;
        int ntok;
        ntok = ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 20))
                                           : int'($urandom_range(0, 6));
        for (int j = 0; j < ntok; j++) begin
            case ($urandom_range(0, 11))
                0, 1, 2: seq.push_back(mk_byte(8'($urandom_range(1, 127))));
                3, 4, 5: begin
                    key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                    seq.push_back(mk_byte(key[23:16]));
                    seq.push_back(mk_byte(key[15:8]));
                    seq.push_back(mk_byte(key[7:0]));
                end
                6: begin
                    seq.push_back(mk_byte(8'($urandom_range(224, 239))));
                    seq.push_back(mk_byte(8'($urandom_range(128, 191))));
                    seq.push_back(mk_byte(8'($urandom_range(128, 191))));
                end
                7: begin
                    seq.push_back(mk_byte(8'($urandom_range(192, 223))));
                    seq.push_back(mk_byte(8'($urandom_range(128, 191))));
                end
                8: seq.push_back(mk_byte(8'($urandom_range(128, 255))));
                9: begin
                    // A lead, often cut short; at the end of a string a cut-short lead is copied raw.
                    seq.push_back(mk_byte(8'($urandom_range(192, 239))));
                    if ($urandom_range(0, 1))
                        seq.push_back(mk_byte(8'($urandom_range(128, 191))));
                end
                10: seq.push_back(mk_write(9'($urandom_range(256, 511)), 24'($urandom),
                                           16'($urandom), 1'($urandom)));
                default: seq.push_back(mk_byte(8'($urandom_range(1, 255))));
            endcase
        end
        if (seq.size() != 0 && !seq[seq.size() - 1].mode && $urandom_range(0, 1)) begin
            tail = seq.pop_back();
            tail.last = 1'b1;
            seq.push_back(tail);
        end else begin
            seq.push_back(mk_text(8'h00, 1'($urandom), 1'b0, 3'd0, 36'd0));
        end
        for (int i = 0; i < seq.size(); i++)
            send_item(seq[i]);
    endtask

    // Output side: random stalls, with quiet stretches while steady is set.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!steady && $urandom_range(0, 4) == 0)
                stall_left = ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3))
                                                        : int'($urandom_range(8, 40));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (gb_expected.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("Unexpected output byte %02h last %0b", m_out_byte, m_out_last);
            end else begin
                want = gb_expected.pop_front();
                if (m_out_byte !== want.b || m_out_last !== want.last) begin
                    fails++;
                    if (fails <= 10)
                        $display("Output byte %0d: expected %02h last %0b, got %02h last %0b",
                                 results_seen, want.b, want.last, m_out_byte, m_out_last);
                end
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out with %0d output bytes still expected", gb_expected.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [10:0] caps [10];
        logic [23:0] key;
        int goal;
        caps = '{11'd1024, 11'd4, 11'd1, 11'd0, 11'd2, 11'd3, 11'd7, 11'd12,
                 11'($urandom_range(13, 1023)), u2g_pkg::CAP_RESET};
        for (int i = 0; i < u2g_pkg::TABLE_DEPTH; i++)
            lut[i] = '0;

        // Directed items at the reset capacity.
        dir_rows.push_back(mk_text(8'h41, 1'b0, 1'b1, 3'd1, {8'h41, 1'b0, 27'd0}));
        dir_rows.push_back(mk_text(8'h7F, 1'b0, 1'b1, 3'd1, {8'h7F, 1'b0, 27'd0}));
        // A zero byte ends the string even without the last flag.
        dir_rows.push_back(mk_text(8'h00, 1'b0, 1'b1, 3'd1, {8'h00, 1'b1, 27'd0}));
        dir_rows.push_back(mk_write(9'd0, 24'hE4B8AD, 16'hD6D0, 1'b1));
        dir_rows.push_back(mk_write(9'd1, 24'hE4B8AD, 16'h0000, 1'b1));
        dir_rows.push_back(mk_write(9'd511, 24'hFFFFFF, 16'hFFFF, 1'b1));
        dir_rows.push_back(mk_write(9'd2, 24'hE38080, 16'h0000, 1'b1));
        dir_rows.push_back(mk_byte(8'hE4));
        dir_rows.push_back(mk_byte(8'hB8));
        dir_rows.push_back(mk_byte(8'hAD));
        dir_rows.push_back(mk_byte(8'hFF));
        dir_rows.push_back(mk_byte(8'hFF));
        dir_rows.push_back(mk_text(8'hFF, 1'b1, 1'b0, 3'd0, 36'd0));
        // An entry whose GB2312 bytes are zero still sends them.
        dir_rows.push_back(mk_byte(8'hE3));
        dir_rows.push_back(mk_byte(8'h80));
        dir_rows.push_back(mk_byte(8'h80));
        dir_rows.push_back(mk_byte(8'hE6));
        dir_rows.push_back(mk_byte(8'h8B));
        dir_rows.push_back(mk_byte(8'h9F));
        dir_rows.push_back(mk_byte(8'hC4));
        dir_rows.push_back(mk_byte(8'h80));
        dir_rows.push_back(mk_text(8'h41, 1'b1, 1'b0, 3'd0, 36'd0));
        dir_rows.push_back(mk_write(9'd0, 24'hE4B8AD, 16'hD6D0, 1'b0));
        dir_rows.push_back(mk_byte(8'hE3));
        dir_rows.push_back(mk_text(8'h81, 1'b1, 1'b0, 3'd0, 36'd0));
        dir_rows.push_back(mk_text(8'h80, 1'b1, 1'b1, 3'd2,
                                   {8'h80, 1'b0, 8'h00, 1'b1, 18'd0}));

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < dir_rows.size(); i++)
            send_item(dir_rows[i]);

        // Load a table with some repeated keys so that the lowest slot has to win.
        for (int i = 0; i < 24; i++) begin
            if (i % 6 == 5)
                key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            else if ($urandom_range(0, 4) != 0)
                key = {8'($urandom_range(224, 239)), 8'($urandom_range(128, 191)),
                       8'($urandom_range(128, 191))};
            else
                key = {8'($urandom_range(128, 255)), 16'($urandom)};
            known_keys.push_back(key);
            send_item(mk_write(9'($urandom_range(0, 511)), key,
                               ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 255))
                                                            : 16'($urandom),
                               $urandom_range(0, 9) != 0));
        end

        for (int p = 0; p < 10; p++) begin
            set_capacity(caps[p]);
            steady = (p == 4);
            goal = items_sent + 13;
            while (items_sent < goal)
                random_string();
        end
        steady = 1'b0;
        settle();

        $display("Sent %0d items (%0d table writes) making up %0d strings, checked %0d bytes.",
                 items_sent, writes_sent, strings_done, results_seen);
        $display("Capacity settings used: %0d, down to zero and up to 1024.", caps_used);
        if (fails == 0 && gb_expected.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d bytes never arrived", fails, gb_expected.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
